// ----- rtl/ucsps_pkg.sv -----
`default_nettype none

package ucsps_pkg;

    localparam int NUM_SERVOS_DEF = 4;
    localparam int MAX_DIGITS_DEF = 3;
    localparam int ANGLE_SLOTS    = 4;
    localparam int OUT_LINES      = 4;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_USED_W = 21;
    localparam int OUT_DATA_W = 24;

    typedef logic [7:0] char_t;
    typedef char_t [ANGLE_SLOTS-1:0] angle_array_t;

    localparam char_t PULSE_OFFSET = 8'd31;
    localparam char_t ANGLE_RESET  = 8'd64;
    localparam char_t CHAR_A       = 8'h41;
    localparam char_t CHAR_F       = 8'h46;
    localparam char_t CHAR_SEMI    = 8'h3B;
    localparam char_t CHAR_PLUS    = 8'h2B;
    localparam char_t CHAR_MINUS   = 8'h2D;
    localparam char_t CHAR_ZERO    = 8'h30;
    localparam char_t CHAR_NINE    = 8'h39;
    localparam char_t CHAR_SPACE   = 8'h20;
    localparam char_t CHAR_TAB     = 8'h09;
    localparam char_t CHAR_CR      = 8'h0D;

    localparam logic OP_TICK = 1'b0;

    // Command letters in the order of their codes.
    typedef enum logic [2:0] {
        LET_A,
        LET_B,
        LET_C,
        LET_D,
        LET_E,
        LET_F
    } letter_t;

    typedef enum logic [1:0] {
        SCAN_BLANK,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_t;

    typedef struct packed {
        char_t duty_a;
        char_t duty_b;
        logic  done;
    } cmd_status_t;

endpackage

`default_nettype wire

// ----- rtl/uart_commanded_servo_pulse_sequencer_core.sv -----
// Path: an accepted item is held in the input register, then its result in the
// result register, which drives m_tdata.
// Throughput: one item per cycle while m_tready does not stall the output.
// Reset: synchronous on aresetn low; both stages empty, counters, slot and lines
// cleared, duties zero, all servo angles 64, no pending command.
`default_nettype none

module uart_commanded_servo_pulse_sequencer_core #(
    parameter int NUM_SERVOS = ucsps_pkg::NUM_SERVOS_DEF,
    parameter int MAX_DIGITS = ucsps_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [7:0] rx_byte
    input  wire logic [ucsps_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [3:0] servo_lines, [11:4] duty_a, [19:12] duty_b, [20] command_done
    output logic [ucsps_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import ucsps_pkg::*;

    logic                   in_valid_reg, in_valid_next;
    logic                   in_op_reg;
    char_t                  in_byte_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;

    logic                   advance;
    logic                   s_fire;
    logic                   tick_en;
    logic                   byte_en;
    logic [NUM_SERVOS-1:0]  lines_next;
    logic [OUT_LINES-1:0]   lines_out;
    angle_array_t           angles;
    cmd_status_t            status_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign tick_en  = advance && (in_op_reg == OP_TICK);
    assign byte_en  = advance && (in_op_reg != OP_TICK);

    ucsps_pulse_gen #(
        .NUM_SERVOS (NUM_SERVOS)
    ) u_pulse_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (tick_en),
        .angles     (angles),
        .lines_next (lines_next)
    );

    ucsps_cmd_parser #(
        .NUM_SERVOS (NUM_SERVOS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_cmd_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_en     (byte_en),
        .rx_byte     (in_byte_reg),
        .angles      (angles),
        .status_next (status_next)
    );

    // Only the first four lines are visible; missing lines read low.
    for (genvar k = 0; k < OUT_LINES; k++) begin : g_lines
        if (k < NUM_SERVOS) begin : g_used
            assign lines_out[k] = lines_next[k];
        end else begin : g_unused
            assign lines_out[k] = 1'b0;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
        end
        if (advance) begin
            out_data_reg <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, status_next.done,
                             status_next.duty_b, status_next.duty_a, lines_out};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/ucsps_pulse_gen.sv -----
`default_nettype none

module ucsps_pulse_gen #(
    parameter int NUM_SERVOS = ucsps_pkg::NUM_SERVOS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    tick_en,
    input  wire ucsps_pkg::angle_array_t angles,
    output logic [NUM_SERVOS-1:0]        lines_next
);
    import ucsps_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SERVOS + 1);

    char_t                  counter_reg, counter_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [NUM_SERVOS-1:0]  line_reg;
    char_t                  counter_inc;
    char_t                  angle_sel;

    always_comb begin
        angle_sel = '0;
        for (int k = 0; k < ANGLE_SLOTS; k++) begin
            if (int'(slot_reg) == k) begin
                angle_sel = angles[k];
            end
        end
    end

    always_comb begin
        counter_inc  = counter_reg + 8'd1;
        counter_next = counter_reg;
        slot_next    = slot_reg;
        lines_next   = line_reg;
        if (tick_en) begin
            counter_next = counter_inc;
            // A wrap of the counter opens the next slot, or after the last slot drops all lines and restarts the frame.
            if (counter_inc == '0) begin
                if (slot_reg < SLOT_W'(NUM_SERVOS)) begin
                    lines_next   = NUM_SERVOS'(1) << slot_reg;
                    counter_next = 8'd0 - (angle_sel + PULSE_OFFSET);
                    slot_next    = slot_reg + SLOT_W'(1);
                end else begin
                    lines_next   = '0;
                    counter_next = '0;
                    slot_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            slot_reg    <= '0;
            line_reg    <= '0;
        end else begin
            counter_reg <= counter_next;
            slot_reg    <= slot_next;
            line_reg    <= lines_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ucsps_cmd_parser.sv -----
`default_nettype none

module ucsps_cmd_parser #(
    parameter int NUM_SERVOS = ucsps_pkg::NUM_SERVOS_DEF,
    parameter int MAX_DIGITS = ucsps_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    byte_en,
    input  wire ucsps_pkg::char_t        rx_byte,
    output ucsps_pkg::angle_array_t      angles,
    output ucsps_pkg::cmd_status_t       status_next
);
    import ucsps_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    angle_array_t       angle_reg, angle_next;
    char_t              duty_a_reg, duty_a_next;
    char_t              duty_b_reg, duty_b_next;
    letter_t            letter_reg, letter_next;
    logic               have_letter_reg, have_letter_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    char_t              digit_reg [MAX_DIGITS];
    logic               store_en;
    logic               done;

    char_t              acc;
    logic               neg;
    scan_t              phase;
    char_t              cmd_value;
    logic               is_letter;

    function automatic logic is_blank(input char_t c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Text to number: blanks, an optional sign, then decimal digits, mod 256.
    always_comb begin
        acc   = '0;
        neg   = 1'b0;
        phase = SCAN_BLANK;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (CNT_W'(i) < count_reg) begin
                case (phase)
                    SCAN_BLANK: begin
                        if (is_blank(digit_reg[i])) begin
                            phase = SCAN_BLANK;
                        end else if (digit_reg[i] == CHAR_PLUS ||
                                     digit_reg[i] == CHAR_MINUS) begin
                            neg   = (digit_reg[i] == CHAR_MINUS);
                            phase = SCAN_DIGITS;
                        end else if (is_digit(digit_reg[i])) begin
                            acc   = {acc[4:0], 3'b000} + {acc[6:0], 1'b0}
                                    + (digit_reg[i] - CHAR_ZERO);
                            phase = SCAN_DIGITS;
                        end else begin
                            phase = SCAN_DONE;
                        end
                    end
                    SCAN_DIGITS: begin
                        if (is_digit(digit_reg[i])) begin
                            acc = {acc[4:0], 3'b000} + {acc[6:0], 1'b0}
                                  + (digit_reg[i] - CHAR_ZERO);
                        end else begin
                            phase = SCAN_DONE;
                        end
                    end
                    default: begin
                        phase = SCAN_DONE;
                    end
                endcase
            end
        end
        cmd_value = neg ? (8'd0 - acc) : acc;
    end

    always_comb begin
        is_letter        = (rx_byte >= CHAR_A) && (rx_byte <= CHAR_F);
        angle_next       = angle_reg;
        duty_a_next      = duty_a_reg;
        duty_b_next      = duty_b_reg;
        letter_next      = letter_reg;
        have_letter_next = have_letter_reg;
        count_next       = count_reg;
        store_en         = 1'b0;
        done             = 1'b0;
        if (byte_en) begin
            if (is_letter) begin
                // A new letter replaces the pending one but keeps the digits.
                letter_next      = letter_t'(3'(rx_byte - CHAR_A));
                have_letter_next = 1'b1;
            end else if (have_letter_reg) begin
                if (rx_byte != CHAR_SEMI && count_reg < CNT_W'(MAX_DIGITS)) begin
                    store_en   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    done             = 1'b1;
                    count_next       = '0;
                    have_letter_next = 1'b0;
                    unique case (letter_reg)
                        LET_A: begin
                            if (NUM_SERVOS > 0) angle_next[0] = cmd_value;
                        end
                        LET_B: begin
                            if (NUM_SERVOS > 1) angle_next[1] = cmd_value;
                        end
                        LET_C: begin
                            duty_a_next = cmd_value + PULSE_OFFSET;
                        end
                        LET_D: begin
                            duty_b_next = cmd_value + PULSE_OFFSET;
                        end
                        LET_E: begin
                            if (NUM_SERVOS > 2) angle_next[2] = cmd_value;
                        end
                        LET_F: begin
                            if (NUM_SERVOS > 3) angle_next[3] = cmd_value;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    assign angles             = angle_reg;
    assign status_next.duty_a = duty_a_next;
    assign status_next.duty_b = duty_b_next;
    assign status_next.done   = done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg       <= {ANGLE_SLOTS{ANGLE_RESET}};
            duty_a_reg      <= '0;
            duty_b_reg      <= '0;
            letter_reg      <= LET_A;
            have_letter_reg <= 1'b0;
            count_reg       <= '0;
        end else begin
            angle_reg       <= angle_next;
            duty_a_reg      <= duty_a_next;
            duty_b_reg      <= duty_b_next;
            letter_reg      <= letter_next;
            have_letter_reg <= have_letter_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (store_en && count_reg == CNT_W'(i)) begin
                digit_reg[i] <= rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_uart_commanded_servo_pulse_sequencer_core.sv -----
module tb_uart_commanded_servo_pulse_sequencer_core;
    import ucsps_pkg::*;

    localparam logic OP_BYTE       = ~OP_TICK;
    localparam int   RANDOM_ITEMS  = 1350;
    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   REPORT_LIMIT  = 10;
    localparam int   DRAIN_CYCLES  = 10;
    localparam int   HOLD_START    = 600;
    localparam int   HOLD_CYCLES   = 250;

    localparam char_t CMD_A = CHAR_A + 8'(LET_A);
    localparam char_t CMD_C = CHAR_A + 8'(LET_C);
    localparam char_t CMD_D = CHAR_A + 8'(LET_D);
    localparam char_t CMD_E = CHAR_A + 8'(LET_E);

    // Same bit order as the used part of m_tdata.
    typedef struct packed {
        logic       done;
        char_t      duty_b;
        char_t      duty_a;
        logic [3:0] lines;
    } servo_status_t;

    typedef struct packed {
        logic          op;
        char_t         data;
        logic          typed;
        servo_status_t status;
    } stim_row_t;

    typedef char_t text_t[$];

    localparam int DIR_ROWS = 25;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{OP_TICK, 8'h00,  1'b1, '{1'b0, 8'd0,  8'd0,  4'd0}},
        '{OP_BYTE, 8'hFF,  1'b1, '{1'b0, 8'd0,  8'd0,  4'd0}},
        '{OP_BYTE, CMD_C,  1'b1, '{1'b0, 8'd0,  8'd0,  4'd0}},
        '{OP_BYTE, CHAR_SEMI, 1'b1, '{1'b1, 8'd0,  8'd31, 4'd0}},
        '{OP_BYTE, CMD_D,  1'b1, '{1'b0, 8'd0,  8'd31, 4'd0}},
        '{OP_BYTE, "2",    1'b0, '0},
        '{OP_BYTE, "5",    1'b0, '0},
        '{OP_BYTE, "5",    1'b0, '0},
        '{OP_BYTE, CHAR_SEMI, 1'b1, '{1'b1, 8'd30, 8'd31, 4'd0}},
        '{OP_BYTE, CMD_C,  1'b0, '0},
        '{OP_BYTE, CHAR_MINUS, 1'b0, '0},
        '{OP_BYTE, "1",    1'b0, '0},
        '{OP_BYTE, CHAR_SEMI, 1'b1, '{1'b1, 8'd30, 8'd30, 4'd0}},
        '{OP_BYTE, CMD_D,  1'b0, '0},
        '{OP_BYTE, CHAR_SPACE, 1'b0, '0},
        '{OP_BYTE, CHAR_PLUS, 1'b0, '0},
        '{OP_BYTE, "7",    1'b0, '0},
        '{OP_BYTE, "9",    1'b1, '{1'b1, 8'd38, 8'd30, 4'd0}},
        '{OP_BYTE, CMD_A,  1'b0, '0},
        '{OP_BYTE, "1",    1'b0, '0},
        '{OP_BYTE, CMD_C,  1'b0, '0},
        '{OP_BYTE, "2",    1'b0, '0},
        '{OP_BYTE, CHAR_SEMI, 1'b0, '0},
        '{OP_BYTE, CMD_E,  1'b0, '0},
        '{OP_BYTE, CHAR_SEMI, 1'b0, '0}
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = OP_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    servo_status_t servo_status_q[$];
    int            mismatches  = 0;
    int            items       = 0;
    int            cycle_count = 0;
    int            rx_cycles   = 0;
    int            hold_left   = 0;
    logic          idle_ok     = 1'b1;

    // Shadow copy of the sequencer state.
    logic [7:0] p_count;
    logic [2:0] p_slot;
    logic [3:0] p_lines;
    char_t      p_angle [ANGLE_SLOTS];
    char_t      p_duty_a;
    char_t      p_duty_b;
    letter_t    p_letter;
    logic       p_armed;
    int         p_ndig;
    char_t      p_text [MAX_DIGITS_DEF];

    uart_commanded_servo_pulse_sequencer_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic is_blank(char_t c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_letter(char_t c);
        return c >= CHAR_A && c <= CHAR_F;
    endfunction

    // Same parse as atoi over the collected text, kept to eight bits.
    function automatic char_t text_value();
        int          i;
        int unsigned acc;
        logic        neg;
        i   = 0;
        acc = 0;
        neg = 1'b0;
        while (i < p_ndig && is_blank(p_text[i]))
            i++;
        if (i < p_ndig && (p_text[i] == CHAR_PLUS || p_text[i] == CHAR_MINUS)) begin
            neg = (p_text[i] == CHAR_MINUS);
            i++;
        end
        while (i < p_ndig && p_text[i] >= CHAR_ZERO && p_text[i] <= CHAR_NINE) begin
            acc = acc * 10 + (p_text[i] - CHAR_ZERO);
            i++;
        end
        if (neg)
            acc = -acc;
        return acc[7:0];
    endfunction

    task automatic sequencer_step(input logic op, input char_t b, output servo_status_t r);
        char_t v;
        logic  done;
        done = 1'b0;
        if (op == OP_TICK) begin
            p_count = p_count + 8'd1;
            if (p_count == 8'd0) begin
                if (p_slot < NUM_SERVOS_DEF) begin
                    p_lines = 4'(1 << p_slot);
                    p_count = 8'd0 - (p_angle[p_slot[1:0]] + PULSE_OFFSET);
                    p_slot  = p_slot + 3'd1;
                end else begin
                    p_lines = '0;
                    p_count = '0;
                    p_slot  = '0;
                end
            end
        end else if (is_letter(b)) begin
            p_letter = letter_t'(3'(b - CHAR_A));
            p_armed  = 1'b1;
        end else if (p_armed) begin
            if (b != CHAR_SEMI && p_ndig < MAX_DIGITS_DEF) begin
                p_text[p_ndig] = b;
                p_ndig++;
            end else begin
                v = text_value();
                case (p_letter)
                    LET_A: p_angle[0] = v;
                    LET_B: p_angle[1] = v;
                    LET_C: p_duty_a = v + PULSE_OFFSET;
                    LET_D: p_duty_b = v + PULSE_OFFSET;
                    LET_E: p_angle[2] = v;
                    LET_F: p_angle[3] = v;
                    default: ;
                endcase
                p_ndig  = 0;
                p_armed = 1'b0;
                done    = 1'b1;
            end
        end
        r = '{done, p_duty_b, p_duty_a, p_lines};
    endtask

    task automatic send_item(input logic op, input char_t b, input logic typed,
                             input servo_status_t want);
        servo_status_t pred;
        if (idle_ok && $urandom_range(0, 99) < 4) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        // Bytes that arrive with no command letter pending leave the state alone.
        if (op == OP_TICK || is_letter(b) || p_armed)
            items++;
        sequencer_step(op, b, pred);
        servo_status_q.push_back(typed ? want : pred);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, char_t'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic send_byte(input char_t b);
        send_item(OP_BYTE, b, 1'b0, '0);
    endtask

    function automatic char_t plain_byte();
        char_t b;
        do b = char_t'($urandom_range(0, 255)); while (is_letter(b));
        return b;
    endfunction

    function automatic text_t decimal_text(input int unsigned v);
        text_t t;
        if (v >= 100)
            t.push_back(CHAR_ZERO + char_t'(v / 100));
        if (v >= 10)
            t.push_back(CHAR_ZERO + char_t'((v / 10) % 10));
        t.push_back(CHAR_ZERO + char_t'(v % 10));
        return t;
    endfunction

    // A letter, up to three text bytes with the odd tick between them, then a ';' or a fourth byte.
    task automatic send_command();
        text_t txt;
        txt = {};
        send_byte(CHAR_A + char_t'($urandom_range(0, 5)));
        case ($urandom_range(0, 5))
            // Negative angles just below zero give short pulses and fast frames.
            0: txt = {CHAR_MINUS, decimal_text($urandom_range(1, 30))};
            1: txt = decimal_text($urandom_range(0, 20));
            2: txt = decimal_text($urandom_range(0, 999));
            3: begin
                txt.push_back($urandom_range(0, 1) ? CHAR_SPACE
                                                   : CHAR_TAB + char_t'($urandom_range(0, 4)));
                txt.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                txt.push_back(CHAR_ZERO + char_t'($urandom_range(0, 9)));
            end
            4: ;
            default: repeat ($urandom_range(1, 3)) txt.push_back(plain_byte());
        endcase
        foreach (txt[i]) begin
            if ($urandom_range(0, 99) < 5)
                send_tick();
            send_byte(txt[i]);
        end
        if (txt.size() == MAX_DIGITS_DEF && $urandom_range(0, 1))
            send_byte(plain_byte());
        else
            send_byte(CHAR_SEMI);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_byte(char_t'($urandom_range(0, 255)));
            1: begin
                // A second letter arrives while digits are already collected.
                send_byte(CHAR_A + char_t'($urandom_range(0, 5)));
                send_byte(CHAR_ZERO + char_t'($urandom_range(0, 9)));
                send_command();
            end
            default: begin
                send_byte(CHAR_A + char_t'($urandom_range(0, 5)));
                repeat ($urandom_range(1, 4)) send_byte(plain_byte());
            end
        endcase
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    always @(posedge aclk) begin : result_check
        servo_status_t got;
        servo_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[OUT_USED_W-1:0];
            if (servo_status_q.size() == 0) begin
                log_mismatch($sformatf("unexpected item: lines %h duty_a %0d duty_b %0d done %b",
                                       got.lines, got.duty_a, got.duty_b, got.done));
            end else begin
                want = servo_status_q.pop_front();
                if (got.lines != want.lines || got.duty_a != want.duty_a ||
                    got.duty_b != want.duty_b || got.done != want.done)
                    log_mismatch($sformatf(
                        "mismatch: lines %h/%h duty_a %0d/%0d duty_b %0d/%0d done %b/%b (exp/act)",
                        want.lines, got.lines, want.duty_a, got.duty_a,
                        want.duty_b, got.duty_b, want.done, got.done));
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a quiet window with none.
    always @(posedge aclk) begin
        rx_cycles <= rx_cycles + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_cycles == HOLD_START) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (rx_cycles > 900 && rx_cycles < 1300) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int pick;
        p_count  = '0;
        p_slot   = '0;
        p_lines  = '0;
        foreach (p_angle[i])
            p_angle[i] = ANGLE_RESET;
        p_duty_a = '0;
        p_duty_b = '0;
        p_letter = LET_A;
        p_armed  = 1'b0;
        p_ndig   = 0;
        foreach (p_text[i])
            p_text[i] = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i])
            send_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].status);

        items = 0;
        while (items < RANDOM_ITEMS) begin
            idle_ok = !(items >= 500 && items < 800);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                repeat ($urandom_range(1, 40)) send_tick();
            else if (pick < 90)
                send_command();
            else
                send_noise();
        end
        s_tvalid <= 1'b0;

        while (servo_status_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- uart_commanded_servo_pulse_sequencer_core.f -----
rtl/ucsps_pkg.sv
rtl/ucsps_pulse_gen.sv
rtl/ucsps_cmd_parser.sv
rtl/uart_commanded_servo_pulse_sequencer_core.sv
verif/tb_uart_commanded_servo_pulse_sequencer_core.sv
